// ----- rtl/core/wctt_pkg.sv -----
// ----------------------------------------------------------------------------
// wctt_pkg
// Shared types and constants for the wrapping compare tick timer.
// ----------------------------------------------------------------------------
package wctt_pkg;

  localparam int COUNT_BITS = 16;
  localparam int OUT_BITS   = 16;
  localparam int CFG_BITS   = 16;
  localparam int DELAY_BITS = 32;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Operation codes carried by a request
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_ACK       = 3'd2,
    OP_SET_DELAY = 3'd3,
    OP_READ_REM  = 3'd4,
    OP_STOP      = 3'd5
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PERIOD    = 2'd0,
    CFG_MAX_DELAY = 2'd1,
    CFG_MIN_DELAY = 2'd2,
    CFG_HOST_MGD  = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_BITS-1:0] PERIOD_RST    = 16'd1000;
  localparam logic [CFG_BITS-1:0] MAX_DELAY_RST = 16'hffff;
  localparam logic [CFG_BITS-1:0] MIN_DELAY_RST = 16'd0;

  typedef struct packed {
    logic [CFG_BITS-1:0] period_ticks;
    logic [CFG_BITS-1:0] max_delay;
    logic [CFG_BITS-1:0] min_delay;
    logic                host_managed;
  } cfg_t;

  typedef struct packed {
    logic                event_res;
    logic [OUT_BITS-1:0] remaining;
    logic [OUT_BITS-1:0] count_now;
    logic                match_pending;
  } res_t;

endpackage

// ----- rtl/core/wctt_core.sv -----
// ----------------------------------------------------------------------------
// wctt_core
// Timer state and per-request update; result formed in the same cycle.
// ----------------------------------------------------------------------------
module wctt_core import wctt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [2:0]            opcode,
  input  logic [DELAY_BITS-1:0] delay_ticks,
  input  cfg_t                  cfg,
  output res_t                  res
);

  cnt_t counter, counter_next;
  cnt_t compare_value, compare_value_next;
  cnt_t next_deadline, next_deadline_next;
  logic running, running_next;
  logic match_irq_enabled, match_irq_enabled_next;
  logic match_flag, match_flag_next;

  cnt_t                counter_inc;
  logic [CFG_BITS-1:0] delay_clamped;

  assign counter_inc   = counter + cnt_t'(1);
  // clamp compares the full 32-bit request against the 16-bit limit
  assign delay_clamped = (delay_ticks > DELAY_BITS'(cfg.max_delay)) ?
                         cfg.max_delay : delay_ticks[CFG_BITS-1:0];

  always_comb begin
    counter_next           = counter;
    compare_value_next     = compare_value;
    next_deadline_next     = next_deadline;
    running_next           = running;
    match_irq_enabled_next = match_irq_enabled;
    match_flag_next        = match_flag;
    res.event_res          = 1'b0;
    res.remaining          = '0;
    case (op_t'(opcode))
      OP_TICK: begin
        if (running) begin
          counter_next = counter_inc;
          if (counter_inc == compare_value) begin
            match_flag_next = 1'b1;
            res.event_res   = match_irq_enabled;
          end
        end
      end
      OP_START: begin
        counter_next           = '0;
        next_deadline_next     = cnt_t'(cfg.period_ticks);
        compare_value_next     = cnt_t'(cfg.period_ticks);
        match_flag_next        = 1'b0;
        match_irq_enabled_next = 1'b1;
        running_next           = 1'b1;
      end
      OP_ACK: begin
        match_flag_next = 1'b0;
        if (!cfg.host_managed) begin
          next_deadline_next = next_deadline + cnt_t'(cfg.period_ticks);
          compare_value_next = next_deadline + cnt_t'(cfg.period_ticks);
        end
      end
      OP_SET_DELAY: begin
        if (delay_clamped > cfg.min_delay) begin
          compare_value_next = counter + cnt_t'(delay_clamped);
        end else begin
          res.event_res = 1'b1;
        end
      end
      OP_READ_REM: begin
        res.remaining = OUT_BITS'(compare_value - counter);
      end
      OP_STOP: begin
        running_next           = 1'b0;
        match_irq_enabled_next = 1'b0;
      end
      default: ;
    endcase
    res.count_now     = OUT_BITS'(counter_next);
    res.match_pending = match_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counter           <= '0;
      compare_value     <= '0;
      next_deadline     <= '0;
      running           <= 1'b0;
      match_irq_enabled <= 1'b0;
      match_flag        <= 1'b0;
    end else if (accept) begin
      counter           <= counter_next;
      compare_value     <= compare_value_next;
      next_deadline     <= next_deadline_next;
      running           <= running_next;
      match_irq_enabled <= match_irq_enabled_next;
      match_flag        <= match_flag_next;
    end
  end

endmodule

// ----- rtl/core/wrapping_compare_tick_timer_top.sv -----
// ----------------------------------------------------------------------------
// wrapping_compare_tick_timer_top
// 16-bit tick-driven counter with one compare register, one result per request.
// ----------------------------------------------------------------------------
// Each request (opcode plus delay) gives exactly one result, registered in the
// output register or, while that is held, in the skid entry. Requests may come
// back to back, one per clock while op_stall is low: timer state is updated in
// the accepting cycle, so the next request sees it at once. The result side has
// an output register and one skid entry, so a request is still taken while the
// previous result waits; op_stall rises only once both are full. Configuration
// (period, delay limits, host managed) is written through cfg_we/cfg_index/
// cfg_data, by the user only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module wrapping_compare_tick_timer_top import wctt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  op_valid,
  output logic                  op_stall,
  input  logic [2:0]            opcode,
  input  logic [DELAY_BITS-1:0] delay_ticks,
  // result channel
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic                  event_res,
  output logic [OUT_BITS-1:0]   remaining,
  output logic [OUT_BITS-1:0]   count_now,
  output logic                  match_pending,
  // configuration
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  cfg_t cfg;
  res_t res_new;
  res_t res_out;
  res_t skid;
  logic skid_valid;
  logic accept;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period_ticks <= PERIOD_RST;
      cfg.max_delay    <= MAX_DELAY_RST;
      cfg.min_delay    <= MIN_DELAY_RST;
      cfg.host_managed <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PERIOD:    cfg.period_ticks <= cfg_data;
        CFG_MAX_DELAY: cfg.max_delay    <= cfg_data;
        CFG_MIN_DELAY: cfg.min_delay    <= cfg_data;
        CFG_HOST_MGD:  cfg.host_managed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stall only with the skid entry full; it is registered, no path from res_stall
  assign op_stall = skid_valid;
  assign accept   = op_valid && !op_stall;

  wctt_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .opcode      (opcode),
    .delay_ticks (delay_ticks),
    .cfg         (cfg),
    .res         (res_new)
  );

  // Output register plus skid entry (two-deep queue, oldest at the output)
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        // no accept possible here: op_stall is high
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_out <= skid;
      end else if (accept) begin
        res_out <= res_new;
      end
    end else if (accept) begin
      skid <= res_new;
    end
  end

  assign event_res     = res_out.event_res;
  assign remaining     = res_out.remaining;
  assign count_now     = res_out.count_now;
  assign match_pending = res_out.match_pending;

  // Skid entry only ever holds a result behind a waiting one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry full with output register empty");

  // A request taken while the output is held must land in the skid entry
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res_stall) |=> (skid_valid && res_valid))
    else $error("request lost while output held");

  // An accepted request always leaves res_valid high next cycle, at the output or behind it in the skid entry
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted request produced no result");

endmodule
